@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the blur modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define VBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define VBB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ rtl/vbb_pkg.sv @@
`default_nettype none
package vbb_pkg;

  localparam int COL_W   = 13;  // column counter, covers widths up to 8192
  localparam int COL_XW  = 14;  // column compares, one bit of headroom
  localparam int SLOT_W  = 7;   // ring slot, covers up to 128 rows
  localparam int SUM_W   = 13;  // 31 rows * 255
  localparam int RCP_W   = 25;
  localparam int PROD_W  = SUM_W + RCP_W;
  localparam int K_W     = 5;   // window tap counter, up to 30
  localparam int FRAC_W  = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = 2;

  // floor(2^24 / (2r+1)) for r = 0..15
  localparam logic [RCP_W-1:0] RECIP [16] = '{
    25'd16777216, 25'd5592405, 25'd3355443, 25'd2396745,
    25'd1864135,  25'd1525201, 25'd1290555, 25'd1118481,
    25'd986895,   25'd883011,  25'd798915,  25'd729444,
    25'd671088,   25'd621378,  25'd578524,  25'd541200
  };

  typedef enum logic [2:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_COL_START = 3'd3,
    REG_COL_END   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] image_width;
    logic [15:0] image_height;
    logic [3:0]  blur_radius;
    logic [10:0] col_start;
    logic [11:0] col_end;
  } cfg_t;

  // one classified pixel on its way to the back end
  typedef struct packed {
    logic [31:0]       pixel;
    logic [COL_W-1:0]  col;
    logic [15:0]       row;
    logic [SLOT_W-1:0] slot;
    logic [3:0]        rad;
    logic              emit;
    logic [15:0]       first;
    logic [15:0]       stop;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_MUL,
    ST_EMIT
  } back_state_e;

endpackage
`default_nettype wire

@@ rtl/vbb_front.sv @@
`default_nettype none
module vbb_front import vbb_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] pixel_in_i,
  input  wire logic        full_i,
  output logic             push_o,
  output job_t             job_o
);

  localparam int RING = 2 * MAX_RADIUS + 2;

  logic [COL_W-1:0]  col_q, col_d, col;
  logic [15:0]       row_q, row_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [COL_XW-1:0] w_raw, w;
  logic [15:0]       h;
  logic [3:0]        rad;
  logic              last_row, wrap, in_range, row_ge_rad, accept;

  assign w_raw = COL_XW'(cfg_i.image_width);

  always_comb begin
    if (w_raw == '0) begin
      w = COL_XW'(1);
    end else if (w_raw > COL_XW'(MAX_WIDTH)) begin
      w = COL_XW'(MAX_WIDTH);
    end else begin
      w = w_raw;
    end
  end

  assign h   = (cfg_i.image_height == '0) ? 16'd1 : cfg_i.image_height;
  assign rad = (32'(cfg_i.blur_radius) > MAX_RADIUS) ? 4'(MAX_RADIUS) : cfg_i.blur_radius;

  // width lowered mid-row: current pixel ends the row
  assign col        = (COL_XW'(col_q) >= w) ? COL_W'(w - COL_XW'(1)) : col_q;
  assign wrap       = (COL_XW'(col) + COL_XW'(1)) >= w;
  assign last_row   = row_q >= (h - 16'd1);
  assign row_ge_rad = row_q >= 16'(rad);
  assign in_range   = (col >= COL_W'(cfg_i.col_start)) && (col < COL_W'(cfg_i.col_end));

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign push_o     = accept;

  always_comb begin
    job_o.pixel = pixel_in_i;
    job_o.col   = col;
    job_o.row   = row_q;
    job_o.slot  = slot_q;
    job_o.rad   = rad;
    job_o.emit  = in_range && (last_row || row_ge_rad);
    job_o.first = row_ge_rad ? (row_q - 16'(rad)) : 16'd0;
    job_o.stop  = last_row ? row_q : job_o.first;
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (accept) begin
      if (wrap) begin
        col_d = '0;
        if (last_row) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row_q + 16'd1;
          slot_d = (slot_q == SLOT_W'(RING - 1)) ? '0 : slot_q + SLOT_W'(1);
        end
      end else begin
        col_d = col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/vbb_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"
module vbb_fifo import vbb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      empty_o
);

  job_t                q_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QPTR_W:0]     cnt_q;

  assign full_o  = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W+1)'(1);
      end
    end
  end

  `VBB_NEVER(a_no_push_full, push_i && full_o, "push into full queue")
  `VBB_NEVER(a_no_pop_empty, pop_i && empty_o, "pop from empty queue")
  `VBB_ASSERT(a_cnt_bound, cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH), "queue count overflow")

endmodule
`default_nettype wire

@@ rtl/vbb_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module vbb_back import vbb_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 15
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  empty_i,
  input  wire job_t  job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [31:0] blurred_pixel_o,
  output logic [15:0] out_row_o,
  output logic [10:0] out_col_o,
  output logic        run_last_o
);

  localparam int RING = 2 * MAX_RADIUS + 2;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SW   = $clog2(RING);

  logic [31:0] mem_q [RING][MAX_WIDTH];

  back_state_e       state_q, state_d;
  job_t              job_q;
  logic [15:0]       y_q;
  logic [K_W-1:0]    k_q;
  logic [SUM_W-1:0]  sum_q [4];
  logic [PROD_W-1:0] prod_q [4];
  logic [31:0]       rd_q;
  logic              rd_vld_q, out_vld_q, out_free;
  logic [K_W-1:0]    k_last;
  logic signed [17:0] r_s;
  logic [15:0]       r_cl, row_dist;
  logic [SLOT_W-1:0] d7, slot_rd;

  assign out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign k_last      = K_W'({job_q.rad, 1'b0});

  // row of this tap, clamped into 0..current row, then its ring slot
  always_comb begin
    r_s = $signed({2'b00, y_q}) - $signed(18'(job_q.rad)) + $signed(18'(k_q));
    if (r_s < 0) begin
      r_cl = '0;
    end else if (r_s > $signed({2'b00, job_q.row})) begin
      r_cl = job_q.row;
    end else begin
      r_cl = r_s[15:0];
    end
    row_dist = job_q.row - r_cl;
    d7       = SLOT_W'(row_dist);
    if (job_q.slot >= d7) begin
      slot_rd = job_q.slot - d7;
    end else begin
      slot_rd = job_q.slot + SLOT_W'(RING) - d7;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && job_i.emit) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (k_q == k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_MUL;
      ST_MUL:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = (y_q == job_q.stop) ? ST_IDLE : ST_SUM;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SUM);
      if (state_q == ST_EMIT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // line store: pixel written when its item leaves the queue
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mem_q[job_i.slot[SW-1:0]][job_i.col[CW-1:0]] <= job_i.pixel;
    end
    if (state_q == ST_SUM) begin
      rd_q <= mem_q[slot_rd[SW-1:0]][job_q.col[CW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          job_q <= job_i;
          y_q   <= job_i.first;
          k_q   <= '0;
          for (int c = 0; c < 4; c++) begin
            sum_q[c] <= '0;
          end
        end
      end
      ST_SUM, ST_DRAIN: begin
        k_q <= k_q + K_W'(1);
        if (rd_vld_q) begin
          for (int c = 0; c < 4; c++) begin
            sum_q[c] <= sum_q[c] + SUM_W'(rd_q[8*c +: 8]);
          end
        end
      end
      ST_MUL: begin
        for (int c = 0; c < 4; c++) begin
          prod_q[c] <= PROD_W'(sum_q[c]) * PROD_W'(RECIP[job_q.rad]);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          for (int c = 0; c < 4; c++) begin
            blurred_pixel_o[8*c +: 8] <= prod_q[c][FRAC_W +: 8];
          end
          out_row_o  <= y_q;
          out_col_o  <= 11'(job_q.col);
          run_last_o <= (y_q == job_q.stop);
          y_q        <= y_q + 16'd1;
          k_q        <= '0;
          for (int c = 0; c < 4; c++) begin
            sum_q[c] <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  `VBB_ASSERT(a_tap_bound, (state_q == ST_SUM) |-> (k_q <= k_last), "tap counter past window")
  `VBB_ASSERT(a_drain_has_read, (state_q == ST_DRAIN) |-> rd_vld_q, "drain without read data")
  `VBB_ASSERT(a_out_hold, (out_vld_q && !out_ready_i) |=> out_vld_q, "result dropped while stalled")

endmodule
`default_nettype wire

@@ rtl/vertical_box_blur_argb32.sv @@
`default_nettype none
// Vertical box blur, clamped edges, for 32-bit ARGB pixels in raster order.
// Program image_width, image_height, blur_radius and the output column
// window while the block is idle. Each accepted pixel is stored in a ring of
// 2*MAX_RADIUS+2 rows per column; row y of a column is produced when row y+R
// arrives, and the last row of the frame produces every row still owed for
// its column, in ascending order, run_last marking the final one. Channels
// are (sum * floor(2^24/(2R+1))) >> 24, so a value may be one below the mean.
// Rate: the front takes one pixel per cycle whenever the four-entry queue
// has room. For each item the back pops it, then for each output pixel it
// makes 2R+1 reads of the single-read-port line store, one drain, one
// multiply and one emit; it takes no new item until the last one is done.
// Outputs sit in a register, so the back keeps computing while a result
// waits. The line store has no reset and no clearing pass.
module vertical_box_blur_argb32 import vbb_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] pixel_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      blurred_pixel_o,
  output logic [15:0]      out_row_o,
  output logic [10:0]      out_col_o,
  output logic             run_last_o
);

  cfg_t cfg_q;
  logic push, full, pop, empty;
  job_t job_in, job_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 12'd2048;
      cfg_q.image_height <= 16'd2048;
      cfg_q.blur_radius  <= 4'd1;
      cfg_q.col_start    <= 11'd0;
      cfg_q.col_end      <= 12'd2048;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_WIDTH:     cfg_q.image_width  <= cfg_wdata_i[11:0];
        REG_HEIGHT:    cfg_q.image_height <= cfg_wdata_i;
        REG_RADIUS:    cfg_q.blur_radius  <= cfg_wdata_i[3:0];
        REG_COL_START: cfg_q.col_start    <= cfg_wdata_i[10:0];
        REG_COL_END:   cfg_q.col_end      <= cfg_wdata_i[11:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // front: position tracking, clamps, output classification
  vbb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_in_i (pixel_in_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  vbb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  // back: line store, window sums, scaling, output register
  vbb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .job_i           (job_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .blurred_pixel_o (blurred_pixel_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .run_last_o      (run_last_o)
  );

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
module tb import vbb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING      = 32;        // rows held per column in the line store
  localparam int WMAX      = 2048;
  localparam int SETTLE    = 2500;      // worst flush backlog of a full queue, padded
  localparam int CYCLE_CAP = 5000000;

  typedef struct {
    logic [31:0] pix;
    logic [15:0] row;
    logic [10:0] col;
    logic        last;
  } blur_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic [31:0] pixel_in_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o, out_valid_o, run_last_o;
  logic [31:0] blurred_pixel_o;
  logic [15:0] out_row_o;
  logic [10:0] out_col_o;

  vertical_box_blur_argb32 u_dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the block: registers, position and line store
  logic [11:0] sh_width;
  logic [15:0] sh_height;
  logic [3:0]  sh_radius;
  logic [10:0] sh_col_start;
  logic [11:0] sh_col_end;
  int unsigned pos_row, pos_col;
  logic [31:0] line_ring [RING][WMAX];

  blur_out_t   blur_q[$];
  int          n_errors = 0;
  int          n_sent = 0;
  bit          quiet = 1'b0;   // no idling on either side while set
  bit          valid_up = 1'b0;
  int unsigned cycles = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h (row %0d col %0d) at %0t",
             what, got, want, out_row_o, out_col_o, $realtime);
    n_errors++;
  endtask

  // clamped vertical window sum times the reciprocal, per channel
  function automatic logic [31:0] window_mean(int unsigned y, int unsigned col,
                                              int unsigned last, int unsigned rad);
    int unsigned acc [4];
    longint unsigned recip, v;
    int r;
    logic [31:0] p, res;
    recip = (64'd1 << 24) / (2 * rad + 1);
    acc = '{0, 0, 0, 0};
    res = '0;
    for (int i = -int'(rad); i <= int'(rad); i++) begin
      r = int'(y) + i;
      if (r < 0) r = 0;
      if (r > int'(last)) r = last;
      p = line_ring[r % RING][col];
      for (int c = 0; c < 4; c++) acc[c] += p[8*c +: 8];
    end
    for (int c = 0; c < 4; c++) begin
      v = (acc[c] * recip) >> 24;
      res[8*c +: 8] = v[7:0];
    end
    return res;
  endfunction

  // store one pixel and queue every blurred pixel it releases
  task automatic absorb_pixel(input logic [31:0] pix);
    int unsigned w, h, rad, col, row, first, stop;
    bit last_row;
    blur_out_t e;
    w = (sh_width == 0) ? 1 : sh_width;
    if (w > WMAX) w = WMAX;
    h = (sh_height == 0) ? 1 : sh_height;
    rad = sh_radius;
    if (pos_col >= w) pos_col = w - 1;
    col = pos_col;
    row = pos_row;
    line_ring[row % RING][col] = pix;
    last_row = row >= h - 1;
    if (col >= sh_col_start && col < sh_col_end) begin
      if (last_row) begin
        first = (row >= rad) ? row - rad : 0;
        stop = row;
      end else if (row >= rad) begin
        first = row - rad;
        stop = first;
      end else begin
        first = 1;
        stop = 0;
      end
      if (first <= stop)
        for (int unsigned y = first; y <= stop; y++) begin
          e.pix = window_mean(y, col, row, rad);
          e.row = y[15:0];
          e.col = col[10:0];
          e.last = (y == stop);
          blur_q.push_back(e);
        end
    end
    if (col + 1 >= w) begin
      pos_col = 0;
      pos_row = last_row ? 0 : ((row + 1) & 16'hFFFF);
    end else begin
      pos_col = col + 1;
    end
  endtask

  // one item on the pixel channel, then maybe a random gap
  task automatic send_pixel(input logic [31:0] pix);
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    valid_up = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_pixel(pix);
    n_sent++;
    if (!quiet && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drop_valid();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
      @(posedge clk_i);
    end
  endtask

  // all results back, then let silent items drain
  task automatic wait_idle();
    drop_valid();
    while (blur_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_WIDTH:     sh_width = val[11:0];
      REG_HEIGHT:    sh_height = val[15:0];
      REG_RADIUS:    sh_radius = val[3:0];
      REG_COL_START: sh_col_start = val[10:0];
      REG_COL_END:   sh_col_end = val[11:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input int w, input int h, input int r, input int cs, input int ce);
    wait_idle();
    cfg_write(REG_WIDTH, 16'(w));
    cfg_write(REG_HEIGHT, 16'(h));
    cfg_write(REG_RADIUS, 16'(r));
    cfg_write(REG_COL_START, 16'(cs));
    cfg_write(REG_COL_END, 16'(ce));
  endtask

  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return {$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
                 $urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00};
      default: return $urandom;
    endcase
  endfunction

  // ---- directed tests ----

  // every channel at both extremes, normal and bottom-flush rows
  task automatic test_extremes();
    logic [31:0] pat [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_FF00,
                             32'h00FF_00FF, 32'hFFFF_FFFF, 32'h0000_0000};
    set_frame(2, 3, 1, 0, 2048);
    foreach (pat[i]) send_pixel(pat[i]);
  endtask

  // largest radius clamps both edges onto a two-row frame
  task automatic test_max_radius();
    set_frame(1, 2, 15, 0, 2);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8001_7FFE);
  endtask

  // zero width and height act as one
  task automatic test_zero_dims();
    set_frame(0, 0, 0, 0, 1);
    send_pixel(32'hA5A5_5A5A);
    send_pixel(32'h1234_5678);
  endtask

  // reversed, then empty column window: pixels stored, nothing comes out
  task automatic test_empty_window();
    set_frame(2, 1, 2, 2047, 0);
    send_pixel($urandom);
    send_pixel($urandom);
    wait_idle();
    cfg_write(REG_COL_START, 16'd5);
    cfg_write(REG_COL_END, 16'd5);
    send_pixel($urandom);
    send_pixel($urandom);
  endtask

  // tall frame cut short: the current row becomes the last one
  task automatic test_height_cut();
    set_frame(1, 65535, 2, 0, 2048);
    repeat (4) send_pixel(pick_pixel());
    wait_idle();
    cfg_write(REG_HEIGHT, 16'd2);
    send_pixel(pick_pixel());
  endtask

  // width over the limit, then lowered under the current column
  task automatic test_width_cut();
    set_frame(4095, 1, 3, 0, 2048);
    send_pixel(pick_pixel());
    send_pixel(pick_pixel());
    send_pixel(pick_pixel());
    wait_idle();
    cfg_write(REG_WIDTH, 16'd2);
    send_pixel(pick_pixel());
  endtask

  // ---- random frames ----
  task automatic test_random_frames();
    int w, h, r, cs, ce, frame_no;
    frame_no = 0;
    while (n_sent < 380) begin
      w = $urandom_range(6, 1);
      h = $urandom_range(8, 1);
      r = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
      if ($urandom_range(5) == 0) begin
        w = $urandom_range(2, 1);
        h = $urandom_range(36, 10);
      end
      if ($urandom_range(3) == 0) begin
        cs = $urandom_range(w);
        ce = $urandom_range(w + 1);
      end else begin
        cs = 0;
        ce = w;
      end
      quiet = (frame_no >= 6 && frame_no < 10);
      set_frame(w, h, r, cs, ce);
      repeat (w * h) send_pixel(pick_pixel());
      frame_no++;
    end
    quiet = 1'b0;
  endtask

  // result side: random stalls, quiet stretches hold ready high
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
  end

  // compare each accepted result with the oldest pending one
  always @(posedge clk_i) begin
    blur_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blur_q.size() == 0) begin
        report("unexpected result", blurred_pixel_o, 32'h0);
      end else begin
        e = blur_q.pop_front();
        if (blurred_pixel_o !== e.pix) report("pixel", blurred_pixel_o, e.pix);
        if (out_row_o !== e.row) report("row", out_row_o, e.row);
        if (out_col_o !== e.col) report("col", out_col_o, e.col);
        if (run_last_o !== e.last) report("run_last", run_last_o, e.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout with %0d results pending", blur_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    sh_width = 2048;
    sh_height = 2048;
    sh_radius = 1;
    sh_col_start = 0;
    sh_col_end = 2048;
    pos_row = 0;
    pos_col = 0;
    foreach (line_ring[i, j]) line_ring[i][j] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_max_radius();
    test_zero_dims();
    test_empty_window();
    test_height_cut();
    test_width_cut();
    test_random_frames();
    wait_idle();
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
